// ===== rtl/hcs_pkg.sv =====
// hcs_pkg: shared types and constants for the histogram contrast stretch block
// transaction payload structs, controller state type, fixed field widths
// no dependencies
package hcs_pkg;

  // fixed widths of the transaction fields
  localparam int GREY_W = 16;

  // digit width of the serial multiplier
  localparam int MUL_DIGIT = 4;

  // full scale after reset
  localparam logic [GREY_W-1:0] MAX_GREY_RESET = 16'd255;

  // command codes
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_STRETCH = 1'b1;

  // input transaction
  typedef struct packed {
    logic              cmd;
    logic [GREY_W-1:0] pixel;
    logic              first;
  } hcs_in_t;

  // output transaction
  typedef struct packed {
    logic [GREY_W-1:0] value;
    logic              flat;
  } hcs_out_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_OUT
  } hcs_state_t;

endpackage

// ===== rtl/hcs_mul.sv =====
// hcs_mul: digit-serial unsigned multiplier, one MUL_DIGIT-bit digit of b per cycle
// multiplier digits enter msb first through a shift register, product accumulates
// depends on hcs_pkg
module hcs_mul #(
  parameter int PB = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [PB-1:0] a,
  input  logic [PB-1:0] b,
  output logic          done,
  output logic [2*PB-1:0] prod
);
  import hcs_pkg::*;

  localparam int ND = (PB + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int BW = ND * MUL_DIGIT;
  localparam int CW = $clog2(ND + 1);

  logic            busy;
  logic [CW-1:0]   cnt;
  logic [PB-1:0]   mcand;
  logic [BW-1:0]   bsh;
  logic [2*PB-1:0] acc;
  logic [2*PB-1:0] acc_next;
  logic [PB+MUL_DIGIT-1:0] partial;
  logic            last;

  // one partial product per cycle, accumulator shifted by one digit
  assign partial  = mcand * bsh[BW-1 -: MUL_DIGIT];
  assign acc_next = {acc[2*PB-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}} + (2*PB)'(partial);
  assign last     = busy && (cnt == CW'(1));

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= last;
      if (start) begin
        busy <= 1'b1;
      end else if (last) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      bsh   <= BW'(b);
      acc   <= '0;
      cnt   <= CW'(ND);
    end else if (busy) begin
      acc <= acc_next;
      bsh <= bsh << MUL_DIGIT;
      cnt <= cnt - CW'(1);
    end
  end

  assign prod = acc;

endmodule

// ===== rtl/hcs_div.sv =====
// hcs_div: radix-2 restoring divider, one quotient bit per cycle, saturating at lim
// quotient bits shift into the low half of the dividend register
// depends on hcs_pkg
module hcs_div #(
  parameter int PB = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*PB-1:0] num,
  input  logic [PB-1:0]   den,
  input  logic [PB-1:0]   lim,
  output logic            done,
  output logic [PB-1:0]   quo
);
  import hcs_pkg::*;

  localparam int CW = $clog2(PB + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [PB-1:0] rem;
  logic [PB-1:0] lo;
  logic [PB-1:0] dsr;
  logic          ovf;
  logic [PB:0]   trial;
  logic [PB:0]   diff;
  logic          ge;
  logic          last;

  // trial subtract of the divisor from the shifted remainder
  assign trial = {rem, lo[PB-1]};
  assign diff  = trial - (PB+1)'(dsr);
  assign ge    = trial >= (PB+1)'(dsr);
  assign last  = busy && (cnt == CW'(1));

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= last;
      if (start) begin
        busy <= 1'b1;
      end else if (last) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath: a high half at or above the divisor means a quotient past PB bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[2*PB-1:PB];
      lo  <= num[PB-1:0];
      dsr <= den;
      ovf <= num[2*PB-1:PB] >= den;
      cnt <= CW'(PB);
    end else if (busy) begin
      rem <= ge ? diff[PB-1:0] : trial[PB-1:0];
      lo  <= {lo[PB-2:0], ge};
      cnt <= cnt - CW'(1);
    end
  end

  // saturate to full scale
  assign quo = (ovf || (lo > lim)) ? lim : lo;

endmodule

// ===== rtl/histogram_contrast_stretch_core.sv =====
// histogram_contrast_stretch_core: measure items are taken back to back while idle.
// stretch items pass through the serial multiplier (4 bits a cycle), then the restoring
// divider (1 bit a cycle), then the output register; no new item is taken until the
// result is loaded there. A flat range skips both units; a result still held under
// out_stall delays the load.
// sync reset: max_grey 255, min all ones, max zero, no result; uses hcs_pkg, hcs_mul, hcs_div
module histogram_contrast_stretch_core #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [hcs_pkg::GREY_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  hcs_pkg::hcs_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output hcs_pkg::hcs_out_t         out_data
);
  import hcs_pkg::*;

  localparam int PB = PIXEL_BITS;

  hcs_state_t        state;
  hcs_state_t        state_next;
  logic [PB-1:0]     max_grey;
  logic [PB-1:0]     low_seen;
  logic [PB-1:0]     high_seen;
  logic [PB-1:0]     den;
  logic              flat;
  logic [PB-1:0]     pix_raw;
  logic [PB-1:0]     pix;
  logic [PB-1:0]     low_base;
  logic [PB-1:0]     high_base;
  logic [PB-1:0]     span;
  logic              flat_now;
  logic              accept;
  logic              measure;
  logic              stretch;
  logic              mul_start;
  logic              div_start;
  logic              load_out;
  logic              mul_done;
  logic              div_done;
  logic [2*PB-1:0]   prod;
  logic [PB-1:0]     quo;

  // pixel limited to full scale
  assign pix_raw = PB'(in_data.pixel);
  assign pix     = (pix_raw > max_grey) ? max_grey : pix_raw;

  assign accept  = in_valid && !in_stall;
  assign measure = accept && (in_data.cmd == CMD_MEASURE);
  assign stretch = accept && (in_data.cmd == CMD_STRETCH);

  // running statistics, restart seeds the minimum with full scale
  assign low_base  = in_data.first ? max_grey : low_seen;
  assign high_base = in_data.first ? '0 : high_seen;
  assign flat_now  = high_seen <= low_seen;
  assign span      = (pix > low_seen) ? (pix - low_seen) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_grey  <= PB'(MAX_GREY_RESET);
      low_seen  <= '1;
      high_seen <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_grey <= PB'(cfg_wr_data);
      end
      if (measure) begin
        low_seen  <= (pix < low_base) ? pix : low_base;
        high_seen <= (pix > high_base) ? pix : high_base;
      end
    end
  end

  // operands held for the divider
  always_ff @(posedge clk) begin
    if (stretch) begin
      den  <= high_seen - low_seen;
      flat <= flat_now;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and unit strobes
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (stretch) begin
          if (flat_now) begin
            state_next = S_OUT;
          end else begin
            mul_start  = 1'b1;
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (mul_done) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // product of offset pixel and full scale
  hcs_mul #(
    .PB (PB)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (span),
    .b     (max_grey),
    .done  (mul_done),
    .prod  (prod)
  );

  // divide by the measured range
  hcs_div #(
    .PB (PB)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod),
    .den   (den),
    .lim   (max_grey),
    .done  (div_done),
    .quo   (quo)
  );

  // output register, frees the core while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.value <= flat ? '0 : GREY_W'(quo);
      out_data.flat  <= flat;
    end
  end

  // a flat result carries a zero value
  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.flat |-> out_data.value == '0)
    else $error("flat result with nonzero value");

  // result never exceeds full scale
  a_full_scale: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.value <= GREY_W'(max_grey))
    else $error("result above max_grey");

  // multiplier finishes only while the controller waits for it
  a_mul_done: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_MUL)
    else $error("multiplier done outside multiply phase");

  // divider finishes only while the controller waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider done outside divide phase");

endmodule
